FILE: rtl/fcb_wnm_pkg.sv
// Shared types, character codes and helpers for the 8.3 wildcard name matcher.
// No dependencies.
`default_nettype none

package fcb_wnm_pkg;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_WILD  = 8'h3F;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    localparam int NAME_LEN = 8;
    localparam int PAT_LEN  = 11;
    localparam int POS_W    = 4;

    localparam logic [POS_W-1:0] POS_NAME0 = POS_W'(0);
    localparam logic [POS_W-1:0] POS_ONE   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_EXT0  = POS_W'(NAME_LEN);
    localparam logic [POS_W-1:0] POS_END   = POS_W'(PAT_LEN);

    localparam int PAT_NAME_W = 64;
    localparam int PAT_EXT_W  = 24;
    localparam int CFG_DATA_W = 64;
    localparam int CFG_IDX_W  = 1;

    localparam logic [PAT_NAME_W-1:0] PAT_NAME_RST = 64'h2020_2020_2020_2020;
    localparam logic [PAT_EXT_W-1:0]  PAT_EXT_RST  = 24'h20_2020;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_NAME = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_EXT  = 1'b1;

    // matcher phase, one-hot
    typedef enum logic [2:0] {
        PH_NAME = 3'b001,
        PH_DOT  = 3'b010,
        PH_EXT  = 3'b100
    } phase_t;

    // one name byte handed to the step logic
    typedef struct packed {
        logic       fire;
        logic [7:0] ch;
    } step_in_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c inside {[8'h61:8'h7A]}) begin
            r = c - 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/fcb_wnm_cfg.sv
// Pattern registers written through the plain configuration port.
// Depends on fcb_wnm_pkg.
`default_nettype none

module fcb_wnm_cfg (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  cfg_we,
    input  wire logic [fcb_wnm_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  wire logic [fcb_wnm_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic      [fcb_wnm_pkg::PAT_NAME_W-1:0]    pattern_name,
    output logic      [fcb_wnm_pkg::PAT_EXT_W-1:0]     pattern_ext
);

    logic [fcb_wnm_pkg::PAT_NAME_W-1:0] pattern_name_reg;
    logic [fcb_wnm_pkg::PAT_EXT_W-1:0]  pattern_ext_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_name_reg <= fcb_wnm_pkg::PAT_NAME_RST;
            pattern_ext_reg  <= fcb_wnm_pkg::PAT_EXT_RST;
        end else if (cfg_we) begin
            case (cfg_idx)
                fcb_wnm_pkg::REG_PATTERN_NAME: begin
                    pattern_name_reg <= cfg_data[fcb_wnm_pkg::PAT_NAME_W-1:0];
                end
                fcb_wnm_pkg::REG_PATTERN_EXT: begin
                    pattern_ext_reg <= cfg_data[fcb_wnm_pkg::PAT_EXT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign pattern_name = pattern_name_reg;
    assign pattern_ext  = pattern_ext_reg;

endmodule

`default_nettype wire

FILE: rtl/fcb_wnm_step.sv
// Match state (phase, pattern position, sticky fail) and the one-byte step logic.
// Depends on fcb_wnm_pkg.
`default_nettype none

module fcb_wnm_step (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire fcb_wnm_pkg::step_in_t                step,
    input  wire logic [fcb_wnm_pkg::PAT_NAME_W-1:0]   pattern_name,
    input  wire logic [fcb_wnm_pkg::PAT_EXT_W-1:0]    pattern_ext,
    output logic                                      verdict
);

    fcb_wnm_pkg::phase_t                 phase_reg, phase_next;
    logic [fcb_wnm_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic                                failed_reg, failed_next;

    logic [7:0] pat_b;
    logic [7:0] ch_up;
    logic       is_end;
    logic       name_done;
    logic       ext_ok_here;
    logic       ext_ok_first;

    // pattern byte at a position; past the extension reads as a space
    function automatic logic [7:0] pat_at(
        input logic [fcb_wnm_pkg::POS_W-1:0]     pos,
        input logic [fcb_wnm_pkg::PAT_NAME_W-1:0] pn,
        input logic [fcb_wnm_pkg::PAT_EXT_W-1:0]  pe
    );
        logic [7:0] r;
        r = fcb_wnm_pkg::CH_SPACE;
        if (pos < fcb_wnm_pkg::POS_EXT0) begin
            r = pn[{pos[2:0], 3'b000} +: 8];
        end else if (pos < fcb_wnm_pkg::POS_END) begin
            case (pos[1:0])
                2'd0:    r = pe[7:0];
                2'd1:    r = pe[15:8];
                2'd2:    r = pe[23:16];
                default: r = fcb_wnm_pkg::CH_SPACE;
            endcase
        end
        return r;
    endfunction

    function automatic logic ends_part(input logic [7:0] b);
        return (b == fcb_wnm_pkg::CH_SPACE) || (b == fcb_wnm_pkg::CH_WILD);
    endfunction

    always_comb begin
        pat_b  = pat_at(pos_reg, pattern_name, pattern_ext);
        ch_up  = fcb_wnm_pkg::upcase(step.ch);
        is_end = (step.ch == fcb_wnm_pkg::CH_NUL);

        // name part is over for this byte: out of bytes, space, or '?' facing a dot
        name_done = (pos_reg >= fcb_wnm_pkg::POS_EXT0)
                 || (pat_b == fcb_wnm_pkg::CH_SPACE)
                 || ((pat_b == fcb_wnm_pkg::CH_WILD) && (step.ch == fcb_wnm_pkg::CH_DOT));

        // end of name accepted by the extension from here / from its start
        ext_ok_here  = (pos_reg >= fcb_wnm_pkg::POS_END) || ends_part(pat_b);
        ext_ok_first = ends_part(pattern_ext[7:0]);

        verdict = 1'b0;
        if (!failed_reg) begin
            case (phase_reg)
                fcb_wnm_pkg::PH_NAME: verdict = (name_done || ends_part(pat_b)) && ext_ok_first;
                fcb_wnm_pkg::PH_DOT:  verdict = ext_ok_first;
                fcb_wnm_pkg::PH_EXT:  verdict = ext_ok_here;
                default:              verdict = 1'b0;
            endcase
        end

        phase_next  = phase_reg;
        pos_next    = pos_reg;
        failed_next = failed_reg;

        if (step.fire) begin
            if (is_end) begin
                phase_next  = fcb_wnm_pkg::PH_NAME;
                pos_next    = fcb_wnm_pkg::POS_NAME0;
                failed_next = 1'b0;
            end else if (!failed_reg) begin
                case (phase_reg)
                    fcb_wnm_pkg::PH_NAME: begin
                        if (name_done) begin
                            if (step.ch == fcb_wnm_pkg::CH_DOT) begin
                                phase_next = fcb_wnm_pkg::PH_EXT;
                                pos_next   = fcb_wnm_pkg::POS_EXT0;
                            end else begin
                                phase_next  = fcb_wnm_pkg::PH_DOT;
                                failed_next = 1'b1;
                            end
                        end else if (pat_b == fcb_wnm_pkg::CH_WILD || pat_b == ch_up) begin
                            pos_next = pos_reg + fcb_wnm_pkg::POS_ONE;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    fcb_wnm_pkg::PH_DOT: begin
                        if (step.ch == fcb_wnm_pkg::CH_DOT) begin
                            phase_next = fcb_wnm_pkg::PH_EXT;
                            pos_next   = fcb_wnm_pkg::POS_EXT0;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    fcb_wnm_pkg::PH_EXT: begin
                        if (pos_reg >= fcb_wnm_pkg::POS_END
                                || pat_b == fcb_wnm_pkg::CH_SPACE) begin
                            failed_next = 1'b1;
                        end else if (pat_b == fcb_wnm_pkg::CH_WILD || pat_b == ch_up) begin
                            pos_next = pos_reg + fcb_wnm_pkg::POS_ONE;
                        end else begin
                            failed_next = 1'b1;
                        end
                    end
                    default: begin
                        failed_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= fcb_wnm_pkg::PH_NAME;
            pos_reg    <= fcb_wnm_pkg::POS_NAME0;
            failed_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            failed_reg <= failed_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/fcb_wildcard_name_match.sv
// Top level of the 8.3 wildcard name matcher: input word register, step logic, result register.
// Depends on fcb_wnm_pkg, fcb_wnm_cfg and fcb_wnm_step.
//
//   channel  | ports                         | carries
//   ---------+-------------------------------+---------------------------------------
//   input    | s_valid s_ready s_name_char   | one name byte per word, zero ends name
//   result   | m_valid m_ready m_is_match    | one verdict word per zero byte
//   config   | cfg_we cfg_idx cfg_data       | 0 name pattern (64b), 1 ext pattern (24b)
//
// One name byte per clock, sustained, except while a zero byte waits on a held verdict. A
// byte is stepped against the pattern once it is held in the input register and, if it is
// the zero byte, its verdict is written into the result register by that step.
// Non-zero bytes never wait on the result side;
// a zero byte waits only while the previous verdict is still held. Reset (synchronous,
// aresetn low) empties both registers, sets the patterns to all spaces and re-arms the
// matcher. The user must write patterns only while no name is in flight (not enforced).
`default_nettype none

module fcb_wildcard_name_match (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [7:0]                          s_name_char,
    // result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_is_match,
    // configuration
    input  wire logic                                cfg_we,
    input  wire logic [fcb_wnm_pkg::CFG_IDX_W-1:0]   cfg_idx,
    input  wire logic [fcb_wnm_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [fcb_wnm_pkg::PAT_NAME_W-1:0] pattern_name;
    logic [fcb_wnm_pkg::PAT_EXT_W-1:0]  pattern_ext;

    // input word register
    logic       in_vld_reg, in_vld_next;
    logic [7:0] in_char_reg;

    // result register
    logic       out_vld_reg, out_vld_next;
    logic       out_match_reg;

    logic                  in_is_end;
    logic                  out_free;
    logic                  step_go;
    logic                  verdict;
    fcb_wnm_pkg::step_in_t step;

    fcb_wnm_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_idx      (cfg_idx),
        .cfg_data     (cfg_data),
        .pattern_name (pattern_name),
        .pattern_ext  (pattern_ext)
    );

    // Only the zero byte produces a word, so only it can be held back by a full result reg.
    assign in_is_end = (in_char_reg == fcb_wnm_pkg::CH_NUL);
    assign out_free  = !out_vld_reg || m_ready;
    assign step_go   = in_vld_reg && (!in_is_end || out_free);
    assign s_ready   = !in_vld_reg || step_go;

    assign step.fire = step_go;
    assign step.ch   = in_char_reg;

    fcb_wnm_step u_step (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .pattern_name (pattern_name),
        .pattern_ext  (pattern_ext),
        .verdict      (verdict)
    );

    always_comb begin
        in_vld_next = in_vld_reg;
        if (s_valid && s_ready) begin
            in_vld_next = 1'b1;
        end else if (step_go) begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (step_go && in_is_end) begin
            out_vld_next = 1'b1;
        end else if (m_ready) begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // payload: no reset needed
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_name_char;
        end
        if (step_go && in_is_end) begin
            out_match_reg <= verdict;
        end
    end

    assign m_valid    = out_vld_reg;
    assign m_is_match = out_match_reg;

endmodule

`default_nettype wire

FILE: rtl/fcb_wnm_chk.sv
// Port-level checks for the wildcard name matcher, bound onto the top level.
// Depends on fcb_wnm_pkg and the top level's ports.
`default_nettype none

module fcb_wnm_chk (
    input wire logic                                aclk,
    input wire logic                                aresetn,
    input wire logic                                s_valid,
    input wire logic                                s_ready,
    input wire logic [7:0]                          s_name_char,
    input wire logic                                m_valid,
    input wire logic                                m_ready,
    input wire logic                                m_is_match
);

    logic acc_end;
    assign acc_end = s_valid && s_ready && (s_name_char == fcb_wnm_pkg::CH_NUL);

    // held verdict word stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_is_match))
        else $error("verdict word changed while stalled");

    // reset empties the result side
    a_rst_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // input only stalls behind a held, untaken verdict
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without a held verdict");

    // a fresh verdict follows an accepted zero byte
    a_verdict_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(acc_end, 2))
        else $error("verdict without a preceding end of name");

endmodule

bind fcb_wildcard_name_match fcb_wnm_chk u_fcb_wnm_chk (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_name_char (s_name_char),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_is_match  (m_is_match)
);

`default_nettype wire
